>>> hw/rtl/ncf_pkg.sv
package ncf_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int NUM_SLOTS   = 9;
   localparam logic [3:0] LAST_SLOT = 4'(NUM_SLOTS - 1);
   localparam int DIV_STAGES  = 17;
   localparam int MAG_W       = 33;
   localparam int WORK_W      = 2 * DIV_STAGES;
   localparam int LEN_W       = 31;
   localparam int CNT_W       = 11;
   localparam logic [LEN_W-1:0] CELL_LEN_RESET = 31'd65536;
   localparam logic [CNT_W-1:0] CELLS_RESET    = 11'd1;

   localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z    = 3'd2;
   localparam logic [2:0] REG_CELL_LENGTH = 3'd3;
   localparam logic [2:0] REG_CELLS_X     = 3'd4;
   localparam logic [2:0] REG_CELLS_Y     = 3'd5;

   typedef struct packed {
      logic dneg;
      logic negp;
      logic negm;
   } div_tag_type;

   typedef struct packed {
      logic [31:0] minus;
      logic [31:0] own;
      logic [31:0] plus;
   } axis_type;

   typedef struct packed {
      axis_type x;
      axis_type y;
      axis_type z;
   } entry_type;

endpackage

>>> hw/rtl/ncf_div.sv
module ncf_div
   import ncf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [MAG_W-1:0]  in_mag,
   input  logic [LEN_W-1:0]  in_len,
   input  div_tag_type       in_tag,
   output logic              out_valid,
   output logic [31:0]       out_quo,
   output logic [LEN_W-1:0]  out_rem,
   output div_tag_type       out_tag
);

   logic                valid_ff [DIV_STAGES];
   logic [LEN_W-1:0]    rem_ff   [DIV_STAGES];
   logic [WORK_W-1:0]   work_ff  [DIV_STAGES];
   div_tag_type         tag_ff   [DIV_STAGES];

   // one restoring step: next dividend bit in at the top, quotient bit out at the bottom
   function automatic logic [LEN_W+WORK_W-1:0] div_step(input logic [LEN_W-1:0] rem,
                                                        input logic [WORK_W-1:0] work,
                                                        input logic [LEN_W-1:0] len);
      logic [LEN_W:0]   t;
      logic [LEN_W-1:0] r;
      logic             qb;
      t  = {rem, work[WORK_W-1]};
      qb = (t >= {1'b0, len});
      r  = qb ? LEN_W'(t - {1'b0, len}) : LEN_W'(t);
      return {r, work[WORK_W-2:0], qb};
   endfunction

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic              v_src;
      logic [LEN_W-1:0]  r_src;
      logic [WORK_W-1:0] w_src;
      div_tag_type       t_src;
      logic [LEN_W+WORK_W-1:0] one;
      logic [LEN_W+WORK_W-1:0] two;

      if (s == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = '0;
         assign w_src = WORK_W'(in_mag);
         assign t_src = in_tag;
      end else begin : g_next
         assign v_src = valid_ff[s-1];
         assign r_src = rem_ff[s-1];
         assign w_src = work_ff[s-1];
         assign t_src = tag_ff[s-1];
      end

      assign one = div_step(r_src, w_src, in_len);
      assign two = div_step(one[LEN_W+WORK_W-1:WORK_W], one[WORK_W-1:0], in_len);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= two[LEN_W+WORK_W-1:WORK_W];
         work_ff[s] <= two[WORK_W-1:0];
         tag_ff[s]  <= t_src;
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = work_ff[DIV_STAGES-1][31:0];
   assign out_rem   = rem_ff[DIV_STAGES-1];
   assign out_tag   = tag_ff[DIV_STAGES-1];

endmodule

>>> hw/rtl/ncf_front.sv
module ncf_front
   import ncf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_pos_x,
   input  logic [31:0]       req_pos_y,
   input  logic [31:0]       req_pos_z,
   input  logic [31:0]       origin_x,
   input  logic [31:0]       origin_y,
   input  logic [31:0]       origin_z,
   input  logic [LEN_W-1:0]  len,
   input  logic              pop,
   output logic              push,
   output entry_type         push_entry
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]  credit_ff, credit_in;
   logic           accept;
   logic           s0_valid_ff;
   logic [32:0]    d_ff [3];
   logic [31:0]    pos_a [3];
   logic [31:0]    org_a [3];
   logic           dv_valid [3];
   logic           p1_valid_ff, p2_valid_ff;
   axis_type       p2_ff [3];

   assign pos_a[0] = req_pos_x;
   assign pos_a[1] = req_pos_y;
   assign pos_a[2] = req_pos_z;
   assign org_a[0] = origin_x;
   assign org_a[1] = origin_y;
   assign org_a[2] = origin_z;

   // items in flight from input to queue head, never more than the queue holds
   assign req_stall = (credit_ff == CW'(DEPTH));
   assign accept    = req_valid && !req_stall;
   assign credit_in = credit_ff + CW'(accept) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s0_valid_ff <= accept;
         p1_valid_ff <= dv_valid[0];
         p2_valid_ff <= p1_valid_ff;
      end
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [MAG_W-1:0] mag;
      logic [34:0]      twod;
      logic [34:0]      nump, numm;
      div_tag_type      tag_in, tag_out, tag1_ff;
      logic [31:0]      quo, a1_ff;
      logic [LEN_W-1:0] rem, r1_ff;
      logic [31:0]      a1_in;
      logic [LEN_W-1:0] r1_in;
      logic [31:0]      r2;
      logic [31:0]      l32;
      logic             h, half, ex0;

      always_ff @(posedge clock) begin
         d_ff[a] <= {pos_a[a][31], pos_a[a]} - {org_a[a][31], org_a[a]};
      end

      assign mag  = d_ff[a][32] ? 33'(-d_ff[a]) : d_ff[a];
      assign twod = {d_ff[a][32], d_ff[a], 1'b0};
      assign nump = twod + {4'b0, len};
      assign numm = twod - {4'b0, len};
      assign tag_in = '{dneg: d_ff[a][32], negp: nump[34], negm: numm[34]};

      ncf_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (s0_valid_ff),
         .in_mag    (mag),
         .in_len    (len),
         .in_tag    (tag_in),
         .out_valid (dv_valid[a]),
         .out_quo   (quo),
         .out_rem   (rem),
         .out_tag   (tag_out)
      );

      // floor quotient and remainder from the magnitude result
      always_comb begin
         if (!tag_out.dneg) begin
            a1_in = quo;
            r1_in = rem;
         end else if (rem == '0) begin
            a1_in = 32'(-quo);
            r1_in = '0;
         end else begin
            a1_in = ~quo;
            r1_in = len - rem;
         end
      end

      always_ff @(posedge clock) begin
         a1_ff   <= a1_in;
         r1_ff   <= r1_in;
         tag1_ff <= tag_out;
      end

      // half-cell offsets: floor adjusts on the remainder, then truncate toward zero
      assign r2   = {r1_ff, 1'b0};
      assign l32  = {1'b0, len};
      assign h    = (r2 >= l32);
      assign half = (r2 == l32);
      assign ex0  = (r1_ff == '0);

      always_ff @(posedge clock) begin
         p2_ff[a].own   <= a1_ff + 32'(tag1_ff.dneg && !ex0);
         p2_ff[a].plus  <= a1_ff + 32'(h) + 32'(tag1_ff.negp && !half);
         p2_ff[a].minus <= a1_ff - 32'd1 + 32'(h) + 32'(tag1_ff.negm && !half);
      end
   end

   assign push         = p2_valid_ff;
   assign push_entry.x = p2_ff[0];
   assign push_entry.y = p2_ff[1];
   assign push_entry.z = p2_ff[2];

endmodule

>>> hw/rtl/ncf_queue.sv
module ncf_queue
   import ncf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output logic       head_valid,
   output entry_type  head_entry
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type     mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/ncf_back.sv
module ncf_back
   import ncf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  entry_type         head_entry,
   output logic              pop,
   input  logic [CNT_W-1:0]  cells_x,
   input  logic [CNT_W-1:0]  cells_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_slot,
   output logic [31:0]       rsp_cell_index,
   output logic              rsp_is_last
);

   logic [2*CNT_W-1:0] plane_ff;
   logic [3:0]         cnt_ff, cnt_in;
   logic               enable, issue;
   logic [2:0]         corner;
   logic [31:0]        sel_x, sel_y, sel_z;
   logic [53:0]        prod_z;
   logic [42:0]        prod_y;
   logic               a_valid_ff;
   logic [3:0]         a_slot_ff;
   logic [31:0]        a_pz_ff, a_py_ff, a_ix_ff;
   logic [31:0]        sum;
   logic               dup;
   logic [31:0]        value;
   logic [31:0]        hist_ff [8];
   logic               rsp_valid_ff;
   logic [3:0]         rsp_slot_ff;
   logic [31:0]        rsp_cell_ff;

   assign enable = !rsp_valid_ff || !rsp_stall;
   assign issue  = enable && head_valid;
   assign pop    = issue && (cnt_ff == LAST_SLOT);
   assign cnt_in = issue ? ((cnt_ff == LAST_SLOT) ? 4'd0 : cnt_ff + 4'd1) : cnt_ff;

   // corner order: x offset on the high bit, z offset on the low bit
   assign corner = 3'(cnt_ff - 4'd1);

   always_comb begin
      if (cnt_ff == 4'd0) begin
         sel_x = head_entry.x.own;
         sel_y = head_entry.y.own;
         sel_z = head_entry.z.own;
      end else begin
         sel_x = corner[2] ? head_entry.x.plus : head_entry.x.minus;
         sel_y = corner[1] ? head_entry.y.plus : head_entry.y.minus;
         sel_z = corner[0] ? head_entry.z.plus : head_entry.z.minus;
      end
   end

   assign prod_z = sel_z * plane_ff;
   assign prod_y = sel_y * cells_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (enable) begin
            a_valid_ff   <= head_valid;
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= cells_x * cells_y;
      if (issue) begin
         a_slot_ff <= cnt_ff;
         a_pz_ff   <= prod_z[31:0];
         a_py_ff   <= prod_y[31:0];
         a_ix_ff   <= sel_x;
      end
   end

   assign sum = a_pz_ff + a_py_ff + a_ix_ff;

   always_comb begin
      dup = 1'b0;
      for (int j = 0; j < 8; j++) begin
         if (4'(j) < a_slot_ff && hist_ff[j] == sum) begin
            dup = 1'b1;
         end
      end
   end

   assign value = dup ? 32'hFFFF_FFFF : sum;

   always_ff @(posedge clock) begin
      if (enable && a_valid_ff) begin
         rsp_slot_ff <= a_slot_ff;
         rsp_cell_ff <= value;
         if (a_slot_ff != LAST_SLOT) begin
            hist_ff[a_slot_ff[2:0]] <= value;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_cell_index = rsp_cell_ff;
   assign rsp_is_last    = (rsp_slot_ff == LAST_SLOT);

endmodule

>>> hw/rtl/neighbor_cell_finder_core.sv
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_pos_x, req_pos_y, req_pos_z
// rsp       out        rsp_valid/stall    rsp_slot, rsp_cell_index, rsp_is_last
// csr       in         psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// the back end emits one result per cycle while rsp is not stalled,
// nine per item; the pipelined dividers take a new item every cycle
// accept to first result runs through 17 divider stages plus fix-up
// synchronous reset clears all control state and loads the register defaults
// a stalled rsp holds the back end; the front keeps working until the queue fills
module neighbor_cell_finder_core
   import ncf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [31:0]  req_pos_x,
   input  logic [31:0]  req_pos_y,
   input  logic [31:0]  req_pos_z,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [3:0]   rsp_slot,
   output logic [31:0]  rsp_cell_index,
   output logic         rsp_is_last,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [31:0]       origin_x_ff, origin_y_ff, origin_z_ff;
   logic [LEN_W-1:0]  cell_length_ff;
   logic [CNT_W-1:0]  cells_x_ff, cells_y_ff;
   logic [LEN_W-1:0]  len_eff;
   logic              wr_en;
   logic [2:0]        reg_sel;
   logic              push, pop, head_valid;
   entry_type         push_entry, head_entry;

   assign pready  = 1'b1;
   assign reg_sel = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         cell_length_ff <= CELL_LEN_RESET;
         cells_x_ff     <= CELLS_RESET;
         cells_y_ff     <= CELLS_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_ORIGIN_X:    origin_x_ff    <= pwdata;
            REG_ORIGIN_Y:    origin_y_ff    <= pwdata;
            REG_ORIGIN_Z:    origin_z_ff    <= pwdata;
            REG_CELL_LENGTH: cell_length_ff <= pwdata[LEN_W-1:0];
            REG_CELLS_X:     cells_x_ff     <= pwdata[CNT_W-1:0];
            REG_CELLS_Y:     cells_y_ff     <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ORIGIN_X:    prdata = origin_x_ff;
         REG_ORIGIN_Y:    prdata = origin_y_ff;
         REG_ORIGIN_Z:    prdata = origin_z_ff;
         REG_CELL_LENGTH: prdata = 32'(cell_length_ff);
         REG_CELLS_X:     prdata = 32'(cells_x_ff);
         REG_CELLS_Y:     prdata = 32'(cells_y_ff);
         default:         prdata = '0;
      endcase
   end

   // zero length acts as one
   assign len_eff = (cell_length_ff == '0) ? LEN_W'(1) : cell_length_ff;

   ncf_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .origin_x   (origin_x_ff),
      .origin_y   (origin_y_ff),
      .origin_z   (origin_z_ff),
      .len        (len_eff),
      .pop        (pop),
      .push       (push),
      .push_entry (push_entry)
   );

   ncf_queue #(.DEPTH(DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   ncf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .cells_x        (cells_x_ff),
      .cells_y        (cells_y_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot       (rsp_slot),
      .rsp_cell_index (rsp_cell_index),
      .rsp_is_last    (rsp_is_last)
   );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ncf_pkg::*;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } position_type;

   typedef struct {
      logic [3:0]  slot;
      logic [31:0] cell_index;
      logic        is_last;
   } cell_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_slot;
   logic [31:0] rsp_cell_index;
   logic        rsp_is_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   neighbor_cell_finder_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // grid settings as the block should hold them
   logic [31:0]      grid_org_x, grid_org_y, grid_org_z;
   logic [LEN_W-1:0] grid_len;
   logic [CNT_W-1:0] grid_cx, grid_cy;

   position_type    pending_pos[$];
   cell_result_type expected_cells[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_off_cycles = 0;
   int              errors = 0;
   longint          cycle_count = 0;

   function automatic logic [31:0] axis_cell(logic [31:0] p, logic [31:0] org, int offset);
      longint len, num, q;
      len = (grid_len == 0) ? 64'sd1 : longint'(grid_len);
      num = 2 * (longint'($signed(p)) - longint'($signed(org))) + offset * len;
      q = num / (2 * len);
      return q[31:0];
   endfunction

   function automatic logic [31:0] linear_cell(position_type p, int ox, int oy, int oz);
      logic [31:0] ix, iy, iz, plane;
      ix = axis_cell(p.x, grid_org_x, ox);
      iy = axis_cell(p.y, grid_org_y, oy);
      iz = axis_cell(p.z, grid_org_z, oz);
      plane = 32'(grid_cx) * 32'(grid_cy);
      return iz * plane + iy * 32'(grid_cx) + ix;
   endfunction

   task automatic predict_cells(position_type p);
      logic [31:0] cells[NUM_SLOTS];
      cell_result_type r;
      int c;
      cells[0] = linear_cell(p, 0, 0, 0);
      for (int i = 1; i < NUM_SLOTS; i++) begin
         c = i - 1;
         cells[i] = linear_cell(p, c[2] ? 1 : -1, c[1] ? 1 : -1, c[0] ? 1 : -1);
         for (int j = 0; j < i; j++)
            if (cells[i] == cells[j]) cells[i] = 32'hFFFF_FFFF;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         r.slot = 4'(i);
         r.cell_index = cells[i];
         r.is_last = (i == NUM_SLOTS - 1);
         expected_cells = {expected_cells, r};
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) predict_cells('{req_pos_x, req_pos_y, req_pos_z});
         if (pending_pos.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_pos_x <= pending_pos[0].x;
            req_pos_y <= pending_pos[0].y;
            req_pos_z <= pending_pos[0].z;
            void'(pending_pos.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cells.size() == 0) begin
            $error("unexpected item slot %0d index %0h", rsp_slot, rsp_cell_index);
            errors++;
         end else begin
            if (rsp_slot !== expected_cells[0].slot) begin
               $error("slot expected %0d actual %0d", expected_cells[0].slot, rsp_slot);
               errors++;
            end
            if (rsp_cell_index !== expected_cells[0].cell_index) begin
               $error("cell_index expected %0h actual %0h",
                      expected_cells[0].cell_index, rsp_cell_index);
               errors++;
            end
            if (rsp_is_last !== expected_cells[0].is_last) begin
               $error("is_last expected %0b actual %0b", expected_cells[0].is_last,
                      rsp_is_last);
               errors++;
            end
            void'(expected_cells.pop_front());
         end
      end
   end

   // receiver stall, with a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("FAIL neighbor_cell_finder_core");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_ORIGIN_X:    grid_org_x = value;
         REG_ORIGIN_Y:    grid_org_y = value;
         REG_ORIGIN_Z:    grid_org_z = value;
         REG_CELL_LENGTH: grid_len = value[LEN_W-1:0];
         REG_CELLS_X:     grid_cx = value[CNT_W-1:0];
         REG_CELLS_Y:     grid_cy = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] len, logic [31:0] cx, logic [31:0] cy);
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_ORIGIN_Z, oz);
      csr_write(REG_CELL_LENGTH, len);
      csr_write(REG_CELLS_X, cx);
      csr_write(REG_CELLS_Y, cy);
   endtask

   task automatic drain();
      while (pending_pos.size() > 0 || req_valid || expected_cells.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord(logic [31:0] len, int span);
      // mostly near the grid, sometimes anywhere
      if ($urandom_range(9) == 0) return $urandom;
      return 32'($signed($urandom_range(2 * span * 4)) - span * 2) * (len / 2)
             + 32'($urandom_range(3)) - 1;
   endfunction

   task automatic add_item(position_type p);
      pending_pos = {pending_pos, p};
   endtask

   task automatic random_items(int n, logic [31:0] len);
      for (int i = 0; i < n; i++)
         add_item('{random_coord(len, 6), random_coord(len, 6), random_coord(len, 6)});
   endtask

   initial begin
      grid_org_x = 0; grid_org_y = 0; grid_org_z = 0;
      grid_len = CELL_LEN_RESET; grid_cx = CELLS_RESET; grid_cy = CELLS_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, then directed cases
      add_item('{32'h0, 32'h0, 32'h0});
      add_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      add_item('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      add_item('{32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000});
      drain();
      set_grid(32'hFFF0_0000, 32'h0010_0000, 32'h8000_0000, 32'h0002_0000, 10, 7);
      add_item('{32'h0, 32'h0, 32'h0});
      add_item('{32'hFFF0_0000, 32'h0010_0000, 32'h8000_0000});
      add_item('{32'hFFF0_FFFF, 32'h0011_0000, 32'h8001_0000});
      add_item('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      add_item('{32'hFFEF_FFFF, 32'h000F_FFFF, 32'h8000_0001});
      drain();
      // zero length and zero counts, extremes of the counts
      set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0, 0);
      add_item('{32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555});
      add_item('{32'h7FFF_FFFF, 32'h0, 32'hAAAA_AAAA});
      drain();
      set_grid(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1024, 1024);
      add_item('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      add_item('{32'h7FFF_FFFF, 32'h0, 32'h3FFF_FFFF});
      drain();
      set_grid(32'h0, 32'h0, 32'h0, 32'h1, 2047, 2047);
      add_item('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
      add_item('{32'h0, 32'hFFFF_FFFF, 32'h8000_0000});
      drain();

      // random phases over several settings
      send_idle_pct = 15; recv_idle_pct = 63;
      set_grid($urandom, $urandom, $urandom, $urandom_range(32'h40000, 1),
               $urandom_range(1024, 1), $urandom_range(1024, 1));
      random_items(55, grid_len);
      drain();
      send_idle_pct = 63; recv_idle_pct = 15;
      set_grid(32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 4, 3);
      random_items(55, grid_len);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      set_grid($urandom, $urandom, $urandom, $urandom, $urandom_range(16, 1),
               $urandom_range(16, 1));
      @(posedge clock);
      hold_off_cycles = 300;
      random_items(60, grid_len);
      drain();

      if (errors == 0) begin
         $display("PASS neighbor_cell_finder_core");
      end else begin
         $display("FAIL neighbor_cell_finder_core");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/ncf_pkg.sv
hw/rtl/ncf_div.sv
hw/rtl/ncf_front.sv
hw/rtl/ncf_queue.sv
hw/rtl/ncf_back.sv
hw/rtl/neighbor_cell_finder_core.sv
sim/tb_top.sv
